// ----- hdl/krg_pkg.sv -----
// Package with the shared types, codes, constants and key table of the keystroke report generator.
package krg_pkg;

  // Fixed widths and the binary-to-BCD converter geometry.
  localparam int NUM_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_IW     = 4;
  localparam int CONV_STEPS = 32;
  localparam int CONV_CW    = 5;

  // Request codes.
  localparam logic [2:0] OP_CHAR      = 3'd0;
  localparam logic [2:0] OP_NUM_AUTO  = 3'd1;
  localparam logic [2:0] OP_NUM_FIXED = 3'd2;
  localparam logic [2:0] OP_ENTER     = 3'd3;
  localparam logic [2:0] OP_TAB       = 3'd4;

  // Report bytes and character offsets.
  localparam logic [7:0] MOD_SHIFT_L = 8'h02;
  localparam logic [7:0] KC_ENTER    = 8'd40;
  localparam logic [7:0] KC_TAB      = 8'd43;
  localparam logic [7:0] KC_SPACE    = 8'd44;
  localparam logic [7:0] KC_ZERO     = 8'd39;
  localparam logic [7:0] CAP_OFS     = 8'd61;
  localparam logic [7:0] LOW_OFS     = 8'd93;
  localparam logic [7:0] DIG_OFS     = 8'd19;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // How an incoming request is handled.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_NUM  = 2'd2
  } item_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic conv_step;
    logic load_len;
    logic load_press;
    logic load_rel;
  } krg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    item_kind_t kind;
    logic       conv_last;
    logic       out_free;
    logic       last_key;
  } krg_sts_t;

  // Key table: returns {modifier, key_code} for one ASCII character.
  function automatic logic [15:0] map_char(input logic [7:0] c);
    logic [7:0] m;
    logic [7:0] k;
    m = 8'h00;
    k = 8'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      m = MOD_SHIFT_L;
      k = c - CAP_OFS;
    end else if (c inside {[8'h61:8'h7A]}) begin
      k = c - LOW_OFS;
    end else if (c == ASCII_ZERO) begin
      k = KC_ZERO;
    end else if (c inside {[8'h31:8'h39]}) begin
      k = c - DIG_OFS;
    end else if (c == 8'h20) begin
      k = KC_SPACE;
    end
    return {m, k};
  endfunction

endpackage

// ----- hdl/krg_if.sv -----
// Valid/ready channel interfaces for the requests and the keyboard reports.
interface krg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  char_code;
  logic [31:0] number;
  logic [3:0]  digit_count;

  modport source (output valid, output op, output char_code, output number,
                  output digit_count, input ready);
  modport sink (input valid, input op, input char_code, input number,
                input digit_count, output ready);
endinterface

interface krg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier;
  logic [7:0] key_code;
  logic       last;

  modport source (output valid, output modifier, output key_code, output last,
                  input ready);
  modport sink (input valid, input modifier, input key_code, input last,
                output ready);
endinterface

// ----- hdl/keystroke_report_generator_core.sv -----
// Top level of the keystroke report generator: controller, datapath and checks.
//
// Each request is turned into press/release report pairs, one report per
// transfer on the output channel. The block takes one request at a time:
// in_ch.ready is high only while no request is in work. A character, Enter
// or Tab is accepted, and its press and release reports are then loaded
// into the output register in turn, each once the register is free. A
// number first passes through a shift-add-3 binary-to-decimal converter
// that handles one bit per cycle, then the digit count is loaded, then two
// reports per digit follow at one report per cycle while the sink is ready.
// The next request is taken as soon as the final release report has been
// loaded, while it still waits to be taken. Requests with an unknown code,
// or a fixed count of zero or above MAX_DIGITS, are accepted and give no
// reports.
module keystroke_report_generator_core #(
  parameter int MAX_DIGITS = 10
) (
  input logic       clk,
  input logic       rst_n,
  krg_in_if.sink    in_ch,
  krg_out_if.source out_ch
);

  krg_pkg::krg_cmd_t cmd;
  krg_pkg::krg_sts_t sts;
  logic              in_ready;

  krg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  krg_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_ch.op),
    .in_char_code   (in_ch.char_code),
    .in_number      (in_ch.number),
    .in_digit_count (in_ch.digit_count),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_modifier   (out_ch.modifier),
    .out_key_code   (out_ch.key_code),
    .out_last       (out_ch.last)
  );

  assign in_ch.ready = in_ready;

  // A final report is always a release.
  a_last_is_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.modifier == 8'h00 && out_ch.key_code == 8'h00)
    else $error("final report is not a release");

  // A loaded press report shows up as a non-final report.
  a_press_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_press |=> out_ch.valid && !out_ch.last)
    else $error("press report not presented");

  // The last conversion step is followed by the digit count load.
  a_conv_then_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.conv_step && sts.conv_last |=> cmd.load_len)
    else $error("digit count not loaded after conversion");

  // No request is taken while reports are still being produced.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_press || cmd.load_len || cmd.conv_step |-> !in_ch.ready)
    else $error("request taken while busy");

endmodule

// ----- hdl/krg_ctrl.sv -----
// Controller state machine that sequences conversion and report emission.
module krg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  krg_pkg::krg_sts_t sts,
  output krg_pkg::krg_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_LEN   = 5'b00100,
    S_PRESS = 5'b01000,
    S_REL   = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (sts.kind)
            krg_pkg::KIND_KEY: state_nxt = S_PRESS;
            krg_pkg::KIND_NUM: state_nxt = S_CONV;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.load_len = 1'b1;
        state_nxt    = S_PRESS;
      end
      S_PRESS: begin
        if (sts.out_free) begin
          cmd.load_press = 1'b1;
          state_nxt      = S_REL;
        end
      end
      S_REL: begin
        if (sts.out_free) begin
          cmd.load_rel = 1'b1;
          state_nxt    = sts.last_key ? S_IDLE : S_PRESS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/krg_dp.sv -----
// Datapath: request decode, shift-add-3 decimal conversion, digit store and report register.
module krg_dp #(
  parameter int MAX_DIGITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  krg_pkg::krg_cmd_t cmd,
  output krg_pkg::krg_sts_t sts,
  input  logic [2:0]        in_op,
  input  logic [7:0]        in_char_code,
  input  logic [31:0]       in_number,
  input  logic [3:0]        in_digit_count,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_modifier,
  output logic [7:0]        out_key_code,
  output logic              out_last
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int IW = (CW > krg_pkg::BCD_IW) ? CW : krg_pkg::BCD_IW;

  // Working registers.
  logic [krg_pkg::NUM_W-1:0]   bin_r;
  logic [3:0]                  digit_store_r [krg_pkg::BCD_DIGITS];
  logic [krg_pkg::CONV_CW-1:0] conv_cnt_r;
  logic [3:0]                  cnt_r;
  logic                        auto_r;
  logic                        digit_mode_r;
  logic [7:0]                  key_mod_r;
  logic [7:0]                  key_code_r;
  logic [CW-1:0]               digits_left_r;
  logic                        out_valid_r;
  logic [7:0]                  out_mod_r;
  logic [7:0]                  out_key_r;
  logic                        out_last_r;

  logic [3:0]    bcd_adj [krg_pkg::BCD_DIGITS];
  logic [3:0]    bcd_nxt [krg_pkg::BCD_DIGITS];
  logic [IW-1:0] auto_len;
  logic [IW-1:0] len_sel;
  logic [IW-1:0] idx;
  logic [3:0]    cur_digit;
  logic [15:0]   char_map;
  logic [15:0]   digit_map;
  logic          fixed_ok;

  // Request decode.
  assign char_map = krg_pkg::map_char(in_char_code);
  assign fixed_ok = (in_digit_count != 4'd0) &&
                    (IW'(in_digit_count) <= IW'(MAX_DIGITS));

  // Status to the controller.
  always_comb begin
    case (in_op)
      krg_pkg::OP_CHAR, krg_pkg::OP_ENTER, krg_pkg::OP_TAB: sts.kind = krg_pkg::KIND_KEY;
      krg_pkg::OP_NUM_AUTO:  sts.kind = krg_pkg::KIND_NUM;
      krg_pkg::OP_NUM_FIXED: sts.kind = fixed_ok ? krg_pkg::KIND_NUM : krg_pkg::KIND_NONE;
      default:               sts.kind = krg_pkg::KIND_NONE;
    endcase
    sts.conv_last = (conv_cnt_r == krg_pkg::CONV_CW'(krg_pkg::CONV_STEPS - 1));
    sts.out_free  = !out_valid_r || out_ready;
    sts.last_key  = (digits_left_r == CW'(1));
  end

  // One shift-add-3 step: adjust each digit, then shift the whole word left.
  always_comb begin
    for (int i = 0; i < krg_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i] = (digit_store_r[i] >= 4'd5) ? digit_store_r[i] + 4'd3 : digit_store_r[i];
    end
    bcd_nxt[0] = {bcd_adj[0][2:0], bin_r[krg_pkg::NUM_W-1]};
    for (int i = 1; i < krg_pkg::BCD_DIGITS; i++) begin
      bcd_nxt[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
    end
  end

  // Digit count: highest nonzero digit for automatic length, else the requested count.
  always_comb begin
    auto_len = IW'(1);
    for (int i = 0; i < krg_pkg::BCD_DIGITS; i++) begin
      if (digit_store_r[i] != 4'd0) begin
        auto_len = IW'(i + 1);
      end
    end
    if (auto_r) begin
      len_sel = (auto_len > IW'(MAX_DIGITS)) ? IW'(MAX_DIGITS) : auto_len;
    end else begin
      len_sel = IW'(cnt_r);
    end
  end

  // Current digit, most significant first; positions above the converter read as zero.
  always_comb begin
    idx = IW'(digits_left_r) - IW'(1);
    if (idx < IW'(krg_pkg::BCD_DIGITS)) begin
      cur_digit = digit_store_r[idx[krg_pkg::BCD_IW-1:0]];
    end else begin
      cur_digit = 4'd0;
    end
    digit_map = krg_pkg::map_char(krg_pkg::ASCII_ZERO + {4'h0, cur_digit});
  end

  // Request and conversion registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bin_r        <= in_number;
      cnt_r        <= in_digit_count;
      auto_r       <= (in_op == krg_pkg::OP_NUM_AUTO);
      digit_mode_r <= (in_op == krg_pkg::OP_NUM_AUTO) || (in_op == krg_pkg::OP_NUM_FIXED);
      conv_cnt_r   <= '0;
      for (int i = 0; i < krg_pkg::BCD_DIGITS; i++) begin
        digit_store_r[i] <= 4'd0;
      end
      case (in_op)
        krg_pkg::OP_ENTER: begin
          key_mod_r  <= 8'h00;
          key_code_r <= krg_pkg::KC_ENTER;
        end
        krg_pkg::OP_TAB: begin
          key_mod_r  <= 8'h00;
          key_code_r <= krg_pkg::KC_TAB;
        end
        default: begin
          key_mod_r  <= char_map[15:8];
          key_code_r <= char_map[7:0];
        end
      endcase
    end else if (cmd.conv_step) begin
      bin_r      <= {bin_r[krg_pkg::NUM_W-2:0], 1'b0};
      conv_cnt_r <= conv_cnt_r + krg_pkg::CONV_CW'(1);
      for (int i = 0; i < krg_pkg::BCD_DIGITS; i++) begin
        digit_store_r[i] <= bcd_nxt[i];
      end
    end
  end

  // Keys still to type.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_left_r <= '0;
    end else if (cmd.accept) begin
      digits_left_r <= CW'(1);
    end else if (cmd.load_len) begin
      digits_left_r <= CW'(len_sel);
    end else if (cmd.load_rel) begin
      digits_left_r <= digits_left_r - CW'(1);
    end
  end

  // Report output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_press || cmd.load_rel) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_press) begin
      out_mod_r  <= digit_mode_r ? 8'h00 : key_mod_r;
      out_key_r  <= digit_mode_r ? digit_map[7:0] : key_code_r;
      out_last_r <= 1'b0;
    end else if (cmd.load_rel) begin
      out_mod_r  <= 8'h00;
      out_key_r  <= 8'h00;
      out_last_r <= sts.last_key;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_modifier = out_mod_r;
  assign out_key_code = out_key_r;
  assign out_last     = out_last_r;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the keystroke report generator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIGITS  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;

  // One keyboard report as it leaves the block.
  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] key_code;
    logic       last;
  } report_t;

  logic clk;
  logic rst_n;

  krg_in_if  in_ch();
  krg_out_if out_ch();

  keystroke_report_generator_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  report_t pending_reports[$];
  int      fail_count;
  int      cycle_count;
  bit      idle_on;
  int      hold_stretch;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Known values on every input from time zero.
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.op          = krg_pkg::OP_CHAR;
    in_ch.char_code   = 8'h00;
    in_ch.number      = 32'h0;
    in_ch.digit_count = 4'h0;
    fail_count        = 0;
    cycle_count       = 0;
    idle_on           = 1'b0;
    hold_stretch      = 0;
  end

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Key table: ASCII character to modifier byte and HID usage code.
  function automatic void key_for_char(input logic [7:0] c, output logic [7:0] m,
                                       output logic [7:0] k);
    m = 8'h00;
    k = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      // Capitals: shifted letter keys starting at usage 4.
      m = krg_pkg::MOD_SHIFT_L;
      k = 8'd4 + (c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      k = 8'd4 + (c - 8'h61);
    end else if (c == 8'h30) begin
      // Zero sits after nine on the keyboard row.
      k = 8'd39;
    end else if (c >= 8'h31 && c <= 8'h39) begin
      k = 8'd30 + (c - 8'h31);
    end else if (c == 8'h20) begin
      k = krg_pkg::KC_SPACE;
    end
  endfunction

  // A keystroke is a press followed by an all-zero release.
  function automatic void expect_keystroke(input logic [7:0] m, input logic [7:0] k,
                                           input logic final_one);
    pending_reports.push_back('{m, k, 1'b0});
    pending_reports.push_back('{8'h00, 8'h00, final_one});
  endfunction

  // Types the lowest len decimal digits of value, most significant first.
  function automatic void expect_digits(input logic [31:0] value, input int len);
    logic [3:0] digits[MAX_DIGITS];
    logic [31:0] rest;
    logic [7:0] m;
    logic [7:0] k;
    rest = value;
    for (int i = len - 1; i >= 0; i--) begin
      digits[i] = 4'(rest % 10);
      rest = rest / 10;
    end
    for (int i = 0; i < len; i++) begin
      key_for_char(8'h30 + digits[i], m, k);
      expect_keystroke(m, k, i == len - 1);
    end
  endfunction

  // Works out all reports that one accepted request causes.
  function automatic void expect_reports(input logic [2:0] op, input logic [7:0] ch,
                                         input logic [31:0] num, input logic [3:0] cnt);
    logic [7:0] m;
    logic [7:0] k;
    logic [31:0] rest;
    int len;
    case (op)
      krg_pkg::OP_CHAR: begin
        key_for_char(ch, m, k);
        expect_keystroke(m, k, 1'b1);
      end
      krg_pkg::OP_NUM_AUTO: begin
        len = 0;
        rest = num;
        do begin
          len++;
          rest = rest / 10;
        end while (rest != 0);
        if (len > MAX_DIGITS) len = MAX_DIGITS;
        expect_digits(num, len);
      end
      krg_pkg::OP_NUM_FIXED: begin
        // A count of zero or beyond the digit store types nothing.
        if (cnt != 0 && cnt <= MAX_DIGITS) expect_digits(num, cnt);
      end
      krg_pkg::OP_ENTER: expect_keystroke(8'h00, krg_pkg::KC_ENTER, 1'b1);
      krg_pkg::OP_TAB:   expect_keystroke(8'h00, krg_pkg::KC_TAB, 1'b1);
      default: ;
    endcase
  endfunction

  // Offers one request, after a random gap while idle_on is set, and waits for its transfer.
  task automatic send_request(input logic [2:0] op, input logic [7:0] ch,
                              input logic [31:0] num, input logic [3:0] cnt);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op          <= op;
    in_ch.char_code   <= ch;
    in_ch.number      <= num;
    in_ch.digit_count <= cnt;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expect_reports(op, ch, num, cnt);
  endtask

  // Result side: random stall before each report while idle_on is set, or a long hold when asked.
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      wait_n = idle_on ? $urandom_range(0, 16) : 0;
      if (hold_stretch > 0) begin
        wait_n = hold_stretch;
        hold_stretch = 0;
      end
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Each report transfer is compared with the oldest expected report.
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.modifier, out_ch.key_code, out_ch.last};
      if (pending_reports.size() == 0) begin
        report_mismatch($sformatf("unexpected report mod=%h key=%h last=%b",
                                  got.modifier, got.key_code, got.last));
      end else begin
        want = pending_reports.pop_front();
        if (got.modifier !== want.modifier)
          report_mismatch($sformatf("modifier %h, expected %h", got.modifier,
                                    want.modifier));
        if (got.key_code !== want.key_code)
          report_mismatch($sformatf("key_code %h, expected %h", got.key_code,
                                    want.key_code));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("keystroke_report_generator_core test failed");
    $finish;
  end

  // Table boundaries, capitals, space and unmapped characters.
  task automatic test_characters();
    logic [7:0] chars[11];
    chars = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h20, 8'h00, 8'hFF,
              8'h40, 8'h7B};
    foreach (chars[i]) send_request(krg_pkg::OP_CHAR, chars[i], 32'h0, 4'h0);
  endtask

  // Enter, Tab and an unknown request code.
  task automatic test_control_keys();
    send_request(krg_pkg::OP_ENTER, 8'h00, 32'h0, 4'h0);
    send_request(krg_pkg::OP_TAB, 8'hFF, 32'hFFFF_FFFF, 4'hF);
    send_request(3'd7, 8'hFF, 32'hFFFF_FFFF, 4'hF);
  endtask

  // Number typing: automatic length, padding, truncation and bad counts.
  task automatic test_numbers();
    send_request(krg_pkg::OP_NUM_AUTO, 8'h00, 32'd0, 4'h0);
    send_request(krg_pkg::OP_NUM_AUTO, 8'h00, 32'hFFFF_FFFF, 4'h0);
    send_request(krg_pkg::OP_NUM_AUTO, 8'h00, 32'd1000000000, 4'h0);
    send_request(krg_pkg::OP_NUM_FIXED, 8'h00, 32'd123, 4'd0);
    send_request(krg_pkg::OP_NUM_FIXED, 8'h00, 32'd123, 4'd11);
    send_request(krg_pkg::OP_NUM_FIXED, 8'hFF, 32'hFFFF_FFFF, 4'd15);
    send_request(krg_pkg::OP_NUM_FIXED, 8'h00, 32'hFFFF_FFFF, 4'd10);
    send_request(krg_pkg::OP_NUM_FIXED, 8'h00, 32'd7, 4'd3);
    send_request(krg_pkg::OP_NUM_FIXED, 8'h00, 32'd12345, 4'd2);
  endtask

  // Result side holds off for a long stretch while requests keep coming.
  task automatic test_input_stall();
    hold_stretch = 300;
    for (int i = 0; i < 6; i++) begin
      send_request(3'($urandom_range(0, 4)), 8'($urandom_range(0, 255)), $urandom,
                   4'($urandom_range(1, 10)));
    end
  endtask

  // Random requests, weighted toward well-formed numbers and mapped keys.
  task automatic test_random_traffic(input int count);
    logic [2:0] op;
    logic [7:0] ch;
    logic [31:0] num;
    logic [3:0] cnt;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = krg_pkg::OP_CHAR;
      else if (pick < 38) op = krg_pkg::OP_ENTER;
      else if (pick < 46) op = krg_pkg::OP_TAB;
      else if (pick < 66) op = krg_pkg::OP_NUM_AUTO;
      else if (pick < 96) op = krg_pkg::OP_NUM_FIXED;
      else op = 3'($urandom_range(5, 7));
      case ($urandom_range(0, 3))
        0: ch = 8'($urandom_range(8'h41, 8'h5A));
        1: ch = 8'($urandom_range(8'h61, 8'h7A));
        2: ch = 8'(($urandom_range(0, 4) == 0) ? 8'h20 : $urandom_range(8'h30, 8'h39));
        default: ch = 8'($urandom_range(0, 255));
      endcase
      // Shifting spreads the values over all decimal lengths.
      num = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 15) == 0) num = 32'h0;
      cnt = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10));
      send_request(op, ch, num, cnt);
    end
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    test_characters();
    test_control_keys();
    test_numbers();
    idle_on = 1'b0;
    test_input_stall();
    idle_on = 1'b1;
    test_random_traffic(150);
    idle_on = 1'b0;
    test_random_traffic(100);
    idle_on = 1'b1;
    test_random_traffic(100);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    if (fail_count == 0) begin
      $display("keystroke_report_generator_core test passed");
    end else begin
      $display("keystroke_report_generator_core test failed");
    end
    $finish;
  end

endmodule
